// ===== rtl/sha256_block_compress_core_macros.svh =====
// Assertion macros for the SHA-256 compression core RTL.
// Included by the top-level core for its checks; no other dependencies.
`ifndef SHA256_BLOCK_COMPRESS_CORE_MACROS_SVH
`define SHA256_BLOCK_COMPRESS_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, disabled while reset is asserted
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/sha256c_pkg.sv =====
// Types, constants and bit functions for the SHA-256 compression core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package sha256c_pkg;

	localparam int ROUNDS = 64;
	localparam int RND_W  = $clog2(ROUNDS);

	// a..h, index 0 is a
	typedef logic [7:0][31:0] vars_t;

	// control for the message schedule window
	typedef struct packed {
		logic load;   // shift in one message word
		logic shift;  // advance one round, append expanded word
	} sched_ctl_t;

	localparam logic [31:0] IV_TABLE [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== rtl/sha256_block_compress_core.sv =====
// Top level of the SHA-256 block compression core: sequencer, chaining value.
// Depends on sha256c_pkg, sha256c_sched, sha256c_round and the macro header.
`timescale 1ns / 1ps

// Usage:
//   Message channel (msg_valid / msg_stall): one big-endian 32-bit word of an
//   already padded message per transfer, sixteen per 512-bit block. Set
//   new_message on a block's first word to restart from the initial hash;
//   set final_block on a block's sixteenth word to get the digest afterwards.
//   Digest channel (digest_valid / digest_stall): after a final block, eight
//   transfers of digest_word with digest_index 0..7; last_word marks index 7.
//   Timing: the sixteen words of a block load at one per cycle. The sixteenth
//   transfer starts 64 rounds on the single round unit, one per cycle, then
//   the add state folds the result into the chaining value. A final block
//   then delivers its digest as eight word transfers.
//   msg_stall is high during rounds, the add state and digest delivery.
//   A stalled digest word holds; the core waits until all eight are taken.
//   Reset loads the initial hash as chaining value and empties the block.
module sha256_block_compress_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [31:0] msg_word,
	input  logic        new_message,
	input  logic        final_block,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        last_word
);
	import sha256c_pkg::*;

`include "sha256_block_compress_core_macros.svh"

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]       state_q;
	logic [3:0]       wcnt_q;
	logic [RND_W-1:0] rnd_q;
	logic [2:0]       oidx_q;
	logic             final_q;
	vars_t            cv_q;
	vars_t            wv_q;
	vars_t            wv_next;
	logic [31:0]      w_cur;
	sched_ctl_t       sched_ctl;
	logic             in_xfer;
	logic             out_xfer;

	assign msg_stall    = (state_q != ST_LOAD);
	assign in_xfer      = msg_valid && !msg_stall;
	assign digest_valid = (state_q == ST_OUT);
	assign out_xfer     = digest_valid && !digest_stall;
	assign digest_word  = cv_q[oidx_q];
	assign digest_index = oidx_q;
	assign last_word    = (oidx_q == 3'd7);

	assign sched_ctl.load  = in_xfer;
	assign sched_ctl.shift = (state_q == ST_ROUND);

	sha256c_sched u_sched (
		.clk   (clk),
		.ctl   (sched_ctl),
		.word  (msg_word),
		.w_cur (w_cur)
	);

	sha256c_round u_round (
		.cur (wv_q),
		.w   (w_cur),
		.k   (K_TABLE[rnd_q]),
		.nxt (wv_next)
	);

	// sequencer: load words, run rounds, fold into chaining value, emit digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			wcnt_q  <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
			final_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						wcnt_q <= wcnt_q + 4'd1;
						if (wcnt_q == 4'd15) begin
							final_q <= final_block;
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + RND_W'(1);
					if (rnd_q == RND_W'(ROUNDS - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					oidx_q  <= '0;
					state_q <= final_q ? ST_OUT : ST_LOAD;
				end
				ST_OUT: begin
					if (out_xfer) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// chaining value: reload on a new message, accumulate after the rounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= IV_TABLE[i];
			end
		end else if (in_xfer && (wcnt_q == 4'd0) && new_message) begin
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= IV_TABLE[i];
			end
		end else if (state_q == ST_ADD) begin
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= cv_q[i] + wv_q[i];
			end
		end
	end

	// working variables: seed from the chaining value, then advance per round
	always_ff @(posedge clk) begin
		if (in_xfer && (wcnt_q == 4'd15)) begin
			wv_q <= cv_q;
		end else if (state_q == ST_ROUND) begin
			wv_q <= wv_next;
		end
	end

	`SHA_ASSERT_NXT(a_block_starts_rounds, clk, arst_n, in_xfer && (wcnt_q == 4'd15), (state_q == ST_ROUND) && (rnd_q == '0), "sixteenth word did not start the rounds")
	`SHA_ASSERT_NXT(a_rounds_end_in_add, clk, arst_n, (state_q == ST_ROUND) && (rnd_q == RND_W'(ROUNDS - 1)), state_q == ST_ADD, "last round not followed by add")
	`SHA_ASSERT_IMP(a_out_block_aligned, clk, arst_n, digest_valid, (wcnt_q == 4'd0) && final_q, "digest emitted inside a block")
	`SHA_ASSERT_NXT(a_digest_ends, clk, arst_n, out_xfer && last_word, !digest_valid && !msg_stall, "digest runs past its last word")

endmodule

// ===== rtl/sha256c_sched.sv =====
// Rolling sixteen-word message schedule window for the SHA-256 core.
// Depends on sha256c_pkg for the sigma functions and control struct.
`timescale 1ns / 1ps

module sha256c_sched (
	input  logic                   clk,
	input  sha256c_pkg::sched_ctl_t ctl,
	input  logic [31:0]            word,
	output logic [31:0]            w_cur
);
	import sha256c_pkg::*;

	// slot 0 holds the word of the current round, slot 15 the newest
	logic [15:0][31:0] win_q;
	logic [31:0]       w_next;

	// expand W[t+16] from the window
	assign w_next = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
	assign w_cur  = win_q[0];

	// shift in a message word, or advance one round
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			win_q <= {word, win_q[15:1]};
		end else if (ctl.shift) begin
			win_q <= {w_next, win_q[15:1]};
		end
	end

endmodule

// ===== rtl/sha256c_round.sv =====
// One SHA-256 round: compression of a..h with one schedule word and constant.
// Depends on sha256c_pkg for the working variable type and sigma functions.
`timescale 1ns / 1ps

module sha256c_round (
	input  sha256c_pkg::vars_t cur,
	input  logic [31:0]        w,
	input  logic [31:0]        k,
	output sha256c_pkg::vars_t nxt
);
	import sha256c_pkg::*;

	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	// choose and majority
	assign ch  = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
	assign maj = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);

	// round temporaries
	assign t1 = cur[7] + big_sigma1(cur[4]) + ch + k + w;
	assign t2 = big_sigma0(cur[0]) + maj;

	// rotate the working variables
	assign nxt[0] = t1 + t2;
	assign nxt[1] = cur[0];
	assign nxt[2] = cur[1];
	assign nxt[3] = cur[2];
	assign nxt[4] = cur[3] + t1;
	assign nxt[5] = cur[4];
	assign nxt[6] = cur[5];
	assign nxt[7] = cur[6];

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sha256_block_compress_core: random message blocks in, digests out.
// Depends on the core RTL only; carries its own SHA-256 compression predictor.

module tb_top;

	// message word transfer as queued for the driver
	typedef struct {
		logic [31:0] word;
		logic        start_msg;
		logic        end_msg;
	} msg_item_t;

	// one digest word transfer
	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_t;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_WORDS [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam int STIM_ITEMS = 430;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        msg_valid    = 1'b0;
	logic        msg_stall;
	logic [31:0] msg_word     = 32'h0;
	logic        new_message  = 1'b0;
	logic        final_block  = 1'b0;
	logic        digest_valid;
	logic        digest_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  digest_index;
	logic        last_word;

	msg_item_t   stim_q[$];
	digest_t     digest_q[$];
	int          err_count = 0;

	// predictor state: block words, chaining value, words taken so far
	logic [31:0] blk_w [16];
	logic [31:0] chain_h [8] = H_INIT;
	int          words_in = 0;

	// pacing state of the two sides
	bit          send_calm, take_calm;
	int          send_run = 0, take_run = 0;
	int          send_wait = 0, take_wait = 0;
	bit          send_now;
	msg_item_t   send_item;

	sha256_block_compress_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg_word     (msg_word),
		.new_message  (new_message),
		.final_block  (final_block),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.last_word    (last_word)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		logic [63:0] twice;
		twice = {x, x} >> n;
		return twice[31:0];
	endfunction

	// run 64 rounds over the current block and fold them into the chaining value
	function automatic void compress_block();
		logic [31:0] v [8];
		logic [31:0] w, s0, s1, t1, t2, lo, hi;
		int i;
		v = chain_h;
		for (i = 0; i < 64; i++) begin
			if (i < 16) begin
				w = blk_w[i];
			end else begin
				lo = blk_w[(i - 15) & 15];
				hi = blk_w[(i - 2) & 15];
				s0 = ror32(lo, 7) ^ ror32(lo, 18) ^ (lo >> 3);
				s1 = ror32(hi, 17) ^ ror32(hi, 19) ^ (hi >> 10);
				w = blk_w[i & 15] + s0 + blk_w[(i - 7) & 15] + s1;
				blk_w[i & 15] = w;
			end
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_WORDS[i] + w;
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++)
			chain_h[i] = chain_h[i] + v[i];
	endfunction

	// take one message word; queue the digest when a final block completes
	function automatic void absorb_word(input logic [31:0] word, input logic start_flag,
		input logic end_flag);
		digest_t d;
		int i;
		if (words_in == 0 && start_flag)
			chain_h = H_INIT;
		blk_w[words_in] = word;
		if (words_in != 15) begin
			words_in++;
			return;
		end
		words_in = 0;
		compress_block();
		if (!end_flag)
			return;
		for (i = 0; i < 8; i++) begin
			d.word  = chain_h[i];
			d.index = 3'(i);
			d.last  = (i == 7);
			digest_q.push_back(d);
		end
	endfunction

	// draw the idle cycles before the next item; stretches of no idling in between
	task automatic pace(inout bit calm, inout int run, output int gap);
		if (run == 0) begin
			run  = $urandom_range(10, 50);
			calm = ($urandom_range(0, 2) == 0);
		end
		run--;
		gap = calm ? 0 : $urandom_range(0, 17);
	endtask

	function automatic logic [31:0] rand_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 32'h0;
		if (pick == 1)
			return 32'hffffffff;
		return $urandom;
	endfunction

	// message driver: predict on each transfer, then pace the next item
	always @(posedge clk) begin
		if (arst_n) begin
			send_now = 1'b0;
			if (msg_valid && !msg_stall) begin
				absorb_word(msg_word, new_message, final_block);
				pace(send_calm, send_run, send_wait);
				send_now = (send_wait == 0) && (stim_q.size() != 0);
			end else if (!msg_valid) begin
				if (send_wait > 0)
					send_wait--;
				send_now = (send_wait == 0) && (stim_q.size() != 0);
			end
			if (send_now) begin
				send_item = stim_q.pop_front();
				msg_word    <= send_item.word;
				new_message <= send_item.start_msg;
				final_block <= send_item.end_msg;
				msg_valid   <= 1'b1;
			end else if (msg_valid && !msg_stall) begin
				msg_valid <= 1'b0;
			end
		end
	end

	// digest monitor: compare each transfer with the oldest expected word
	always @(posedge clk) begin
		if (arst_n) begin
			if (digest_valid && !digest_stall) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest word %h at index %0d", digest_word, digest_index);
					err_count++;
				end else begin
					if (digest_word !== digest_q[0].word) begin
						$error("digest_word: expected %h, got %h", digest_q[0].word, digest_word);
						err_count++;
					end
					if (digest_index !== digest_q[0].index) begin
						$error("digest_index: expected %0d, got %0d", digest_q[0].index,
							digest_index);
						err_count++;
					end
					if (last_word !== digest_q[0].last) begin
						$error("last_word: expected %0b, got %0b", digest_q[0].last, last_word);
						err_count++;
					end
					void'(digest_q.pop_front());
				end
				pace(take_calm, take_run, take_wait);
				digest_stall <= (take_wait != 0);
			end else if (take_wait > 0) begin
				take_wait--;
				digest_stall <= (take_wait != 0);
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		msg_item_t it;
		int n, b, w, nblk;
		bit fresh;
		bit noise;

		// directed block: word extremes, stray flags that must be ignored
		for (w = 0; w < 16; w++) begin
			case (w)
				0:       it.word = 32'h61626380;
				2, 4, 9: it.word = 32'hffffffff;
				5:       it.word = 32'h80000000;
				6:       it.word = 32'h00000001;
				15:      it.word = 32'h00000018;
				default: it.word = 32'h0;
			endcase
			// new flag counts on the first word only, final flag on the last only
			it.start_msg = (w == 0) || (w == 7) || (w == 15);
			it.end_msg   = (w == 3) || (w == 15);
			stim_q.push_back(it);
		end
		n = 16;

		// random messages; the first continues from the digest just emitted
		fresh = 1'b0;
		while (n < STIM_ITEMS) begin
			nblk = $urandom_range(1, 3);
			for (b = 0; b < nblk; b++) begin
				for (w = 0; w < 16; w++) begin
					noise = ($urandom_range(0, 7) == 0);
					it.word = rand_word();
					if (w == 0)
						it.start_msg = (b == 0) ? fresh : noise;
					else
						it.start_msg = noise;
					noise = ($urandom_range(0, 7) == 0);
					if (w == 15)
						it.end_msg = (b == nblk - 1) ? 1'b1 : noise;
					else
						it.end_msg = noise;
					stim_q.push_back(it);
					n++;
				end
			end
			fresh = ($urandom_range(0, 4) != 0);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all items sent, all digest words seen, then a quiet tail
		while (stim_q.size() != 0 || msg_valid || digest_q.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (err_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("timeout waiting for transfers");
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
